FILE: sv/abwd_pkg.sv
// ----------------------------------------------------------------------------
// abwd_pkg: shared definitions for the archive block word decryptor
// Word widths, cipher constants, the key schedule step and the mixing table,
// which is built at elaboration from the table generator.
// ----------------------------------------------------------------------------
package abwd_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned ROM_DEPTH = 256;
	localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
	localparam int unsigned ROM_SEGS  = 5;
	localparam int unsigned ROM_SEG   = 4;

	localparam logic [WORD_W-1:0] ACC_INIT  = 32'hEEEE_EEEE;
	localparam logic [WORD_W-1:0] KEY_ADD   = 32'h1111_1111;
	localparam logic [WORD_W-1:0] LCG_START = 32'h0010_0001;
	localparam logic [WORD_W-1:0] LCG_MOD   = 32'h002A_AAAB;
	localparam logic [WORD_W-1:0] LCG_MUL   = 32'd125;
	localparam logic [WORD_W-1:0] LCG_INC   = 32'd3;
	localparam logic [WORD_W-1:0] ACC_INC   = 32'd3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ROM_DEPTH-1:0][WORD_W-1:0] mix_table_t;

	// One step of the key schedule. It uses an inversion, shifts, one add and an OR.
	function automatic word_t next_key(input word_t k);
		return ((~k << 21) + KEY_ADD) | (k >> 11);
	endfunction

	// Walks the table generator and keeps one segment. Every row of every
	// segment consumes two generator steps: high half first, then low half.
	// Only evaluated at elaboration.
	function automatic mix_table_t build_mix_table();
		mix_table_t tbl;
		word_t      s;
		logic [15:0] hi;
		tbl = '0;
		s   = LCG_START;
		for (int r = 0; r < ROM_DEPTH; r++) begin
			for (int g = 0; g < ROM_SEGS; g++) begin
				s  = (s * LCG_MUL + LCG_INC) % LCG_MOD;
				hi = s[15:0];
				s  = (s * LCG_MUL + LCG_INC) % LCG_MOD;
				if (g == ROM_SEG) begin
					tbl[r] = {hi, s[15:0]};
				end
			end
		end
		return tbl;
	endfunction

	localparam mix_table_t MIX_TABLE = build_mix_table();

endpackage

FILE: sv/abwd_ram.sv
// ----------------------------------------------------------------------------
// abwd_ram: generic single-clock RAM
// One write port and one read port with a registered read. The read data
// holds its value while the read enable is low.
// ----------------------------------------------------------------------------
module abwd_ram #(
	parameter int unsigned WIDTH = abwd_pkg::WORD_W,
	parameter int unsigned DEPTH = abwd_pkg::ROM_DEPTH,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/archive_block_word_decryptor.sv
// ----------------------------------------------------------------------------
// archive_block_word_decryptor: archive block cipher, one word per beat
// Decrypts a stream of 32-bit words. A beat with first_word set loads
// block_key as the running key and restarts the accumulator before its own
// word is decrypted; last_word is passed through to last_out unchanged.
// After reset the block writes the mixing table into its RAM, one entry per
// cycle, and holds in_stall high until the whole table is written. From
// then on it accepts one beat per cycle unless out_stall holds it back, and
// returns one result per beat in order, through the first stage and then the
// output register. The running key is registered, so the table address for
// a beat is known on acceptance and the RAM read happens in that same cycle.
// The accumulator update is the loop that sets the rate: it closes in the
// first stage, where the registered table word is added in. An output
// register and the first stage together let the block keep taking a beat
// while a finished result waits on out_stall.
// ----------------------------------------------------------------------------
module archive_block_word_decryptor (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] cipher_word,
	input  logic        first_word,
	input  logic [31:0] block_key,
	input  logic        last_word,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] plain_word,
	output logic        last_out
);

	localparam int unsigned AW = abwd_pkg::ROM_AW;

	// Table fill sweep. The top bit of the counter marks the end of the sweep.
	logic [AW:0]   fill_cnt_q;
	logic          fill_done;
	logic          tbl_we;
	logic [AW-1:0] tbl_waddr;
	abwd_pkg::word_t tbl_wdata;

	// Running key, advanced as each beat is accepted.
	abwd_pkg::word_t key_q;
	abwd_pkg::word_t cur_key;

	// Running accumulator, advanced as each beat leaves the first stage.
	abwd_pkg::word_t acc_q;
	abwd_pkg::word_t acc_base;
	abwd_pkg::word_t acc_mix;
	abwd_pkg::word_t plain_next;
	abwd_pkg::word_t acc_next;

	// First stage: the beat waits here while its table word is read.
	logic            valid_s1;
	abwd_pkg::word_t cipher_s1;
	logic            first_s1;
	abwd_pkg::word_t key_s1;
	logic            last_s1;
	abwd_pkg::word_t tbl_rdata;

	// Output register.
	logic            out_valid_q;
	abwd_pkg::word_t plain_q;
	logic            last_q;

	logic in_acc;
	logic out_free;
	logic adv_s1;

	assign fill_done = fill_cnt_q[AW];
	assign tbl_we    = !fill_done;
	assign tbl_waddr = fill_cnt_q[AW-1:0];
	assign tbl_wdata = abwd_pkg::MIX_TABLE[fill_cnt_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q <= '0;
		end else if (!fill_done) begin
			fill_cnt_q <= fill_cnt_q + 1'b1;
		end
	end

	// Handshake. The first stage moves on whenever the output register is
	// empty or being drained, and takes a new beat whenever it moves on or is
	// empty. The RAM read is enabled only on acceptance, so the read data of a
	// held first stage stays put.
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = !fill_done || (valid_s1 && !out_free);
	assign in_acc   = in_valid && !in_stall;

	// A first word takes its key from the beat, any other word continues.
	assign cur_key = first_word ? block_key : key_q;

	abwd_ram #(
		.WIDTH (abwd_pkg::WORD_W),
		.DEPTH (abwd_pkg::ROM_DEPTH),
		.AW    (AW)
	) u_mix_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (in_acc),
		.raddr (cur_key[AW-1:0]),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (in_acc) begin
			key_q <= abwd_pkg::next_key(cur_key);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cipher_s1 <= cipher_word;
			first_s1  <= first_word;
			key_s1    <= cur_key;
			last_s1   <= last_word;
		end
	end

	// Accumulator loop: restart on a first word, add the table word, then
	// fold the plain word back in as plain + 33 * acc + 3.
	assign acc_base   = first_s1 ? abwd_pkg::ACC_INIT : acc_q;
	assign acc_mix    = acc_base + tbl_rdata;
	assign plain_next = cipher_s1 ^ (key_s1 + acc_mix);
	assign acc_next   = plain_next + acc_mix + (acc_mix << 5) + abwd_pkg::ACC_INC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= abwd_pkg::ACC_INIT;
		end else if (adv_s1) begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			plain_q <= plain_next;
			last_q  <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign plain_word = plain_q;
	assign last_out   = last_q;

endmodule

FILE: sv/abwd_checker.sv
// ----------------------------------------------------------------------------
// abwd_checker: port-level checks for the archive block word decryptor
// Tracks how many accepted beats still owe a result and checks capacity,
// latency and output hold against it.
// ----------------------------------------------------------------------------
module abwd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] plain_word,
	input logic        last_out
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// A result only shows for a beat that is still owed one, and the block
	// never holds more than two beats.
	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 2'd0) && (pend_q != 2'd3))
		else $error("result shown with no beat owed or capacity exceeded");

	// With both slots full and the output stalled, no beat may be taken.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd2) && out_stall |-> in_stall)
		else $error("beat accepted while both stages are held");

	// A beat accepted into an empty block shows its result after both stages.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (pend_q == 2'd0) |-> ##2 out_valid)
		else $error("result missing two cycles after acceptance");

	// A stalled result stays and does not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(plain_word) && $stable(last_out))
		else $error("stalled result changed or dropped");

endmodule

bind archive_block_word_decryptor abwd_checker u_abwd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.plain_word (plain_word),
	.last_out   (last_out)
);
